// File: rtl/ptr_pkg.sv
// shared types, codes and color helpers for the planar tile row decoder
// no dependencies; used by ptr_lane and planar_tile_row_to_rgb
`default_nettype none

package ptr_pkg;

    localparam int Lanes          = 8;
    localparam int PlaneWords     = 4;
    localparam int PaletteEntries = 256;
    localparam int IndexWidth     = 8;
    localparam int ColorWidth     = 15;
    localparam int RgbWidth       = 24;
    localparam int CfgIndexWidth  = 1;
    localparam int CfgDataWidth   = 5;

    // command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // configuration register indexes
    localparam logic [CfgIndexWidth-1:0] REG_PIXEL_MODE     = 1'b0;
    localparam logic [CfgIndexWidth-1:0] REG_PALETTE_NUMBER = 1'b1;

    typedef enum logic [1:0] {
        MODE_2BPP   = 2'd0,
        MODE_4BPP   = 2'd1,
        MODE_8BPP   = 2'd2,
        MODE_DIRECT = 2'd3
    } pixel_mode_t;

    // control shared by all lanes
    typedef struct packed {
        logic                  rd_en;
        logic                  wr_en;
        logic [IndexWidth-1:0] wr_addr;
        logic [ColorWidth-1:0] wr_data;
        pixel_mode_t           mode;
        logic [4:0]            palette_number;
    } lane_ctrl_t;

    function automatic logic [7:0] widen5(input logic [4:0] v);
        widen5 = {v, v[4:2]};
    endfunction

    // bgr555 to rgb888
    function automatic logic [RgbWidth-1:0] expand_bgr15(input logic [ColorWidth-1:0] c);
        expand_bgr15 = {widen5(c[4:0]), widen5(c[9:5]), widen5(c[14:10])};
    endfunction

endpackage

`default_nettype wire

// File: rtl/ptr_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module ptr_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/ptr_lane.sv
// one pixel lane: palette index assembly, private palette copy, color widening
// depends on ptr_pkg and ptr_ram
`default_nettype none

module ptr_lane (
    input  wire logic                              clk,
    input  wire ptr_pkg::lane_ctrl_t               ctrl,
    input  wire logic [ptr_pkg::PlaneWords-1:0]    plane_lo,
    input  wire logic [ptr_pkg::PlaneWords-1:0]    plane_hi,
    input  wire logic [ptr_pkg::IndexWidth-1:0]   direct_index,
    output logic      [ptr_pkg::RgbWidth-1:0]     rgb
);

    logic [ptr_pkg::IndexWidth-1:0] raw_index;
    logic [ptr_pkg::IndexWidth-1:0] group;
    logic [ptr_pkg::IndexWidth-1:0] index;
    logic [ptr_pkg::ColorWidth-1:0] color;

    always_comb
    begin
        raw_index = direct_index;
        group     = '0;
        case (ctrl.mode)
            ptr_pkg::MODE_2BPP:
            begin
                raw_index = {6'b0, plane_hi[0], plane_lo[0]};
                group     = {1'b0, ctrl.palette_number, 2'b0};
            end
            ptr_pkg::MODE_4BPP:
            begin
                raw_index = {4'b0, plane_hi[1], plane_lo[1], plane_hi[0], plane_lo[0]};
                group     = {ctrl.palette_number[3:0], 4'b0};
            end
            ptr_pkg::MODE_8BPP:
            begin
                // shifted group always falls off the top
                raw_index = {plane_hi[3], plane_lo[3], plane_hi[2], plane_lo[2],
                             plane_hi[1], plane_lo[1], plane_hi[0], plane_lo[0]};
                group     = '0;
            end
            ptr_pkg::MODE_DIRECT:
            begin
                raw_index = direct_index;
                group     = '0;
            end
            default:
            begin
                raw_index = direct_index;
                group     = '0;
            end
        endcase
    end

    assign index = raw_index + group;

    ptr_ram #(
        .WIDTH (ptr_pkg::ColorWidth),
        .DEPTH (ptr_pkg::PaletteEntries)
    ) u_palette (
        .clk     (clk),
        .wr_en   (ctrl.wr_en),
        .wr_addr (ctrl.wr_addr),
        .wr_data (ctrl.wr_data),
        .rd_en   (ctrl.rd_en),
        .rd_addr (index),
        .rd_data (color)
    );

    assign rgb = ptr_pkg::expand_bgr15(color);

endmodule

`default_nettype wire

// File: rtl/planar_tile_row_to_rgb.sv
// Planar tile row decoder: each accepted word either writes one palette entry
// (no result) or decodes one eight-pixel tile row into eight rgb888 pixels. One
// word is taken every clock once the palette is cleared and while the output
// is not stalled. The accepting edge does the palette read, and the output
// register is loaded from the read stage when it advances. A stalled output is
// absorbed by the read stage for one row before in_ready drops. The eight
// lanes each hold a private copy of the 256-entry palette so all eight lookups
// happen in the same cycle; writes go to all copies at once. After reset the
// block writes zero into every palette entry with in_ready low, so entries
// never written read as black.
// depends on ptr_pkg, ptr_lane, ptr_ram
`default_nettype none

module planar_tile_row_to_rgb (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                cfg_write_en,
    input  wire logic [ptr_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  wire logic [ptr_pkg::CfgDataWidth-1:0]    cfg_data,

    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                command,
    input  wire logic [7:0]                          palette_address,
    input  wire logic [14:0]                         palette_color,
    input  wire logic [15:0]                         plane_word_0,
    input  wire logic [15:0]                         plane_word_1,
    input  wire logic [15:0]                         plane_word_2,
    input  wire logic [15:0]                         plane_word_3,

    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [23:0]                              rgb_pixel_0,
    output logic [23:0]                              rgb_pixel_1,
    output logic [23:0]                              rgb_pixel_2,
    output logic [23:0]                              rgb_pixel_3,
    output logic [23:0]                              rgb_pixel_4,
    output logic [23:0]                              rgb_pixel_5,
    output logic [23:0]                              rgb_pixel_6,
    output logic [23:0]                              rgb_pixel_7
);

    ptr_pkg::pixel_mode_t pixel_mode_reg;
    logic [4:0]           palette_number_reg;

    logic                           clear_busy_reg;
    logic [ptr_pkg::IndexWidth-1:0] clear_addr_reg;

    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_valid_reg;
    logic out_valid_next;

    logic [ptr_pkg::RgbWidth-1:0] pixel_reg [ptr_pkg::Lanes];

    logic in_accept;
    logic decode_accept;
    logic write_accept;
    logic s1_advance;

    logic [15:0]                    words      [ptr_pkg::PlaneWords];
    logic [ptr_pkg::RgbWidth-1:0]   lane_rgb   [ptr_pkg::Lanes];

    ptr_pkg::lane_ctrl_t lane_ctrl;

    assign words[0] = plane_word_0;
    assign words[1] = plane_word_1;
    assign words[2] = plane_word_2;
    assign words[3] = plane_word_3;

    // handshake and pipeline control
    assign in_ready      = !clear_busy_reg && (!s1_valid_reg || !out_valid_reg || out_ready);
    assign in_accept     = in_valid && in_ready;
    assign decode_accept = in_accept && (command == ptr_pkg::CMD_DECODE);
    assign write_accept  = in_accept && (command == ptr_pkg::CMD_WRITE);
    assign s1_advance    = s1_valid_reg && (!out_valid_reg || out_ready);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (decode_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        lane_ctrl.rd_en          = decode_accept;
        lane_ctrl.wr_en          = write_accept || clear_busy_reg;
        lane_ctrl.wr_addr        = clear_busy_reg ? clear_addr_reg : palette_address;
        lane_ctrl.wr_data        = clear_busy_reg ? '0 : palette_color;
        lane_ctrl.mode           = pixel_mode_reg;
        lane_ctrl.palette_number = palette_number_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_mode_reg     <= ptr_pkg::MODE_2BPP;
            palette_number_reg <= '0;
            clear_busy_reg     <= 1'b1;
            clear_addr_reg     <= '0;
            s1_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    ptr_pkg::REG_PIXEL_MODE:
                    begin
                        pixel_mode_reg <= ptr_pkg::pixel_mode_t'(cfg_data[1:0]);
                    end
                    ptr_pkg::REG_PALETTE_NUMBER:
                    begin
                        palette_number_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
            // zero one palette entry per cycle; clearing ends after the entry whose address is all ones
            if (clear_busy_reg)
            begin
                clear_addr_reg <= clear_addr_reg + 1'b1;
                if (&clear_addr_reg)
                begin
                    clear_busy_reg <= 1'b0;
                end
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // lanes, one per pixel; pixel 0 takes the msb of each plane byte
    for (genvar i = 0; i < ptr_pkg::Lanes; i++)
    begin : g_lane
        logic [ptr_pkg::PlaneWords-1:0] plane_lo;
        logic [ptr_pkg::PlaneWords-1:0] plane_hi;

        for (genvar p = 0; p < ptr_pkg::PlaneWords; p++)
        begin : g_plane
            assign plane_lo[p] = words[p][7 - i];
            assign plane_hi[p] = words[p][15 - i];
        end

        ptr_lane u_lane (
            .clk          (clk),
            .ctrl         (lane_ctrl),
            .plane_lo     (plane_lo),
            .plane_hi     (plane_hi),
            .direct_index (words[i / 2][(i % 2) * 8 +: 8]),
            .rgb          (lane_rgb[i])
        );

        // merge lanes into the output word
        always_ff @(posedge clk)
        begin
            if (s1_advance)
            begin
                pixel_reg[i] <= lane_rgb[i];
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign rgb_pixel_0 = pixel_reg[0];
    assign rgb_pixel_1 = pixel_reg[1];
    assign rgb_pixel_2 = pixel_reg[2];
    assign rgb_pixel_3 = pixel_reg[3];
    assign rgb_pixel_4 = pixel_reg[4];
    assign rgb_pixel_5 = pixel_reg[5];
    assign rgb_pixel_6 = pixel_reg[6];
    assign rgb_pixel_7 = pixel_reg[7];

    // a decoded row always lands in the read stage
    a_decode_enters_s1: assert property (@(posedge clk) disable iff (!rst_n)
        decode_accept |=> s1_valid_reg)
        else $error("decode word did not enter the read stage");

    // nothing is taken while the palette is being cleared
    a_idle_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy_reg |-> !in_ready)
        else $error("input ready during palette clear");

    // a row waiting behind a stalled output is kept
    a_s1_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |=> s1_valid_reg)
        else $error("read stage dropped a row during output stall");

endmodule

`default_nettype wire
